>>> src/unique_value_table_defines.svh
// Assertion macros for the unique value table.
// Depends on nothing; expects clk and rst_n in the including module.
`ifndef UNIQUE_VALUE_TABLE_DEFINES_SVH
`define UNIQUE_VALUE_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define UVT_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("unique_value_table: same-cycle check failed");
`define UVT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("unique_value_table: next-cycle check failed");
`else
`define UVT_ASSERT_IMPLY(name, ante, cons)
`define UVT_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> src/uvt_pkg.sv
// Shared types and codes for the unique value table.
// Used by uvt_cmp, unique_value_table and the sim files; depends on nothing.
package uvt_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_SEARCH = 3'd1,
        CMD_MIN    = 3'd2,
        CMD_MAX    = 3'd3,
        CMD_DRAIN  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_BADVAL   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    typedef struct packed {
        logic [2:0]                cmd;
        logic signed [VALUE_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]                status;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] entry_value;
        logic                      last;
    } rsp_item_t;

    // Result of the shared compare unit
    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_flags_t;

endpackage

>>> src/uvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module uvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic                                          rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr_int;

    assign rd_addr_int = rd_addr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // hold read data when no read is issued
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr_int];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/uvt_cmp.sv
// Shared compare unit: equality and signed less-than of two words.
// Depends on uvt_pkg.
module uvt_cmp (
    input  logic [uvt_pkg::VALUE_W-1:0] a,
    input  logic [uvt_pkg::VALUE_W-1:0] b,
    output uvt_pkg::cmp_flags_t         flags
);
    import uvt_pkg::*;

    assign flags.eq = (a == b);
    assign flags.lt = ($signed(a) < $signed(b));

endmodule

>>> src/unique_value_table.sv
// Unique value table top level: sequencer, entry RAM, shared compare unit.
// Depends on uvt_pkg, uvt_ram, uvt_cmp and unique_value_table_defines.svh.
// Insert, search, min and max walk the stored entries with one RAM read and one compare
// per entry; a search or duplicate hit ends the walk early. Rejects and empty-table
// min, max and drain go straight to the result. One command is handled at a time; drain
// reads each entry and emits it before reading the next. Reset clears fill count and drain order; no clear pass.
`include "unique_value_table_defines.svh"

module unique_value_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    // command channel
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  uvt_pkg::cmd_item_t  cmd_item,
    // result channel
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output uvt_pkg::rsp_item_t  rsp_item,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_drain_order
);
    import uvt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT,
        S_DR_ISSUE,
        S_DR_DATA
    } state_t;

    // Sequencer state and working registers
    state_t               state_reg,    state_next;
    cmd_t                 cmd_reg,      cmd_next;
    logic [VALUE_W-1:0]   key_reg,      key_next;
    logic [CNT_W-1:0]     fill_reg,     fill_next;
    logic                 order_reg,    order_next;
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 pend_reg,     pend_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [VALUE_W-1:0]   best_val_reg, best_val_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    status_t              status_reg,   status_next;
    logic [CNT_W-1:0]     drain_cnt_reg, drain_cnt_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_item_t            rsp_item_reg, rsp_item_next;

    // RAM and compare unit hookup
    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    logic [VALUE_W-1:0]   ram_wr_data;
    logic                 ram_rd_en;
    logic [IDX_W-1:0]     ram_rd_addr;
    logic [VALUE_W-1:0]   ram_rd_data;
    logic [VALUE_W-1:0]   cmp_a;
    logic [VALUE_W-1:0]   cmp_b;
    cmp_flags_t           cmp_flags;

    logic                 out_free;
    logic                 drain_last;
    logic                 bad_value;
    logic [CNT_W-1:0]     rev_idx;

    // Map a table index onto the 4-bit position field
    function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
        logic [IDX_W+POS_W-1:0] ext;
        begin
            ext    = {{POS_W{1'b0}}, idx};
            to_pos = ext[POS_W-1:0];
        end
    endfunction

    uvt_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entries (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    uvt_cmp u_cmp (
        .a     (cmp_a),
        .b     (cmp_b),
        .flags (cmp_flags)
    );

    // Output register frees up when empty or being taken this cycle
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign drain_last = ((drain_cnt_reg + CNT_W'(1)) == fill_reg);
    // Reject odd, zero and negative values
    assign bad_value  = cmd_item.value[0] || (cmd_item.value == '0) ||
                        cmd_item.value[VALUE_W-1];
    // Stack order walks down from the newest entry
    assign rev_idx    = fill_reg - CNT_W'(1) - drain_cnt_reg;

    assign cmd_stall  = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_item   = rsp_item_reg;

    // Steer the shared compare unit: min checks entry < best, max checks best < entry,
    // search and duplicate check look for equality with the key.
    always_comb
    begin
        case (cmd_reg)
            CMD_MIN:
            begin
                cmp_a = ram_rd_data;
                cmp_b = best_val_reg;
            end
            CMD_MAX:
            begin
                cmp_a = best_val_reg;
                cmp_b = ram_rd_data;
            end
            default:
            begin
                cmp_a = ram_rd_data;
                cmp_b = key_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        fill_next      = fill_reg;
        order_next     = order_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        best_val_next  = best_val_reg;
        best_idx_next  = best_idx_reg;
        status_next    = status_reg;
        drain_cnt_next = drain_cnt_reg;
        // drop the held result once taken
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_item_next  = rsp_item_reg;

        ram_rd_en   = 1'b0;
        ram_rd_addr = scan_idx_reg[IDX_W-1:0];
        ram_wr_en   = 1'b0;
        ram_wr_addr = fill_reg[IDX_W-1:0];
        ram_wr_data = key_reg;

        if (cfg_valid)
        begin
            order_next = cfg_drain_order;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next       = cmd_t'(cmd_item.cmd);
                    key_next       = cmd_item.value;
                    scan_idx_next  = '0;
                    best_idx_next  = '0;
                    best_val_next  = '0;
                    drain_cnt_next = '0;
                    case (cmd_t'(cmd_item.cmd))
                        CMD_INSERT:
                        begin
                            if (fill_reg == FULL_CNT)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_RESULT;
                            end
                            else if (bad_value)
                            begin
                                status_next = ST_BADVAL;
                                state_next  = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            state_next = S_SCAN;
                        end
                        CMD_MIN, CMD_MAX:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_DRAIN:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_DR_ISSUE;
                            end
                        end
                        default:
                        begin
                            // unknown command: drop it, stay idle
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (pend_reg && cmp_flags.eq &&
                    (cmd_reg == CMD_SEARCH || cmd_reg == CMD_INSERT))
                begin
                    // hit: stop the walk early
                    if (cmd_reg == CMD_SEARCH)
                    begin
                        status_next   = ST_OK;
                        best_idx_next = pend_idx_reg;
                        best_val_next = ram_rd_data;
                    end
                    else
                    begin
                        status_next   = ST_DUP;
                        best_idx_next = '0;
                        best_val_next = '0;
                    end
                    state_next = S_RESULT;
                end
                else if (!pend_reg && scan_idx_reg == fill_reg)
                begin
                    // walk finished without a hit
                    case (cmd_reg)
                        CMD_SEARCH:
                        begin
                            status_next   = ST_NOTFOUND;
                            best_idx_next = '0;
                            best_val_next = '0;
                        end
                        CMD_INSERT:
                        begin
                            ram_wr_en     = 1'b1;
                            status_next   = ST_OK;
                            best_idx_next = fill_reg[IDX_W-1:0];
                            best_val_next = key_reg;
                            fill_next     = fill_reg + CNT_W'(1);
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                    state_next = S_RESULT;
                end
                else
                begin
                    // keep the first entry, then only strictly better ones
                    if (pend_reg && (cmd_reg == CMD_MIN || cmd_reg == CMD_MAX) &&
                        (pend_idx_reg == '0 || cmp_flags.lt))
                    begin
                        best_val_next = ram_rd_data;
                        best_idx_next = pend_idx_reg;
                    end
                    // issue the next read
                    if (scan_idx_reg != fill_reg)
                    begin
                        ram_rd_en     = 1'b1;
                        pend_next     = 1'b1;
                        pend_idx_next = scan_idx_reg[IDX_W-1:0];
                        scan_idx_next = scan_idx_reg + CNT_W'(1);
                    end
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_item_next.status      = status_reg;
                    rsp_item_next.position    = to_pos(best_idx_reg);
                    rsp_item_next.entry_value = best_val_reg;
                    rsp_item_next.last        = 1'b1;
                    state_next                = S_IDLE;
                end
            end

            S_DR_ISSUE:
            begin
                ram_rd_en     = 1'b1;
                ram_rd_addr   = order_reg ? drain_cnt_reg[IDX_W-1:0] : rev_idx[IDX_W-1:0];
                pend_idx_next = ram_rd_addr;
                state_next    = S_DR_DATA;
            end

            S_DR_DATA:
            begin
                // RAM holds its read data while the result side stalls
                if (out_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_item_next.status      = ST_OK;
                    rsp_item_next.position    = to_pos(pend_idx_reg);
                    rsp_item_next.entry_value = ram_rd_data;
                    rsp_item_next.last        = drain_last;
                    drain_cnt_next            = drain_cnt_reg + CNT_W'(1);
                    if (drain_last)
                    begin
                        fill_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DR_ISSUE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            order_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            order_reg     <= order_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        scan_idx_reg  <= scan_idx_next;
        pend_idx_reg  <= pend_idx_next;
        best_val_reg  <= best_val_next;
        best_idx_reg  <= best_idx_next;
        status_reg    <= status_next;
        drain_cnt_reg <= drain_cnt_next;
        rsp_item_reg  <= rsp_item_next;
    end

    // Fill count never passes the table depth
    `UVT_ASSERT_IMPLY(a_fill_bound, 1'b1, fill_reg <= FULL_CNT)
    // A read in flight during a walk always targets a stored entry
    `UVT_ASSERT_IMPLY(a_pend_in_range, state_reg == S_SCAN && pend_reg, pend_idx_reg < fill_reg)
    // Emitting the final drained entry empties the table and frees the block
    `UVT_ASSERT_NEXT(a_drain_empties, state_reg == S_DR_DATA && out_free && drain_last, fill_reg == '0 && state_reg == S_IDLE)
    // An accepted search always starts a walk over the table
    `UVT_ASSERT_NEXT(a_search_walks, cmd_valid && !cmd_stall && cmd_item.cmd == CMD_SEARCH, state_reg == S_SCAN)

endmodule

>>> sim/uvt_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the unique value table: predicts and compares every result item.
// Depends on uvt_pkg; instantiated beside the block by tb_unique_value_table.
module uvt_result_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_stall,
    input  uvt_pkg::cmd_item_t  cmd_item,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  uvt_pkg::rsp_item_t  rsp_item,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic                cfg_drain_order,
    output int                  mismatch_count,
    output int                  pending_count
);
    import uvt_pkg::*;

    logic signed [VALUE_W-1:0] stored_values [TABLE_DEPTH];
    int                        stored_count = 0;
    logic                      drain_oldest_first = 1'b0;
    rsp_item_t                 expected_results [$];
    int                        error_total = 0;

    initial mismatch_count = 0;
    initial pending_count  = 0;

    // Work out the result items one command causes and update the table copy.
    task automatic predict_table_results(input cmd_item_t it);
        rsp_item_t r;
        int        k;
        int        best;
        int        idx;
        bit        hit;
        begin
            r      = '0;
            r.last = 1'b1;
            hit    = 1'b0;
            best   = 0;
            case (it.cmd)
                CMD_INSERT:
                begin
                    if (stored_count >= TABLE_DEPTH)
                        r.status = ST_FULL;
                    else if (it.value[0] || it.value == 0 || it.value[VALUE_W-1])
                        r.status = ST_BADVAL;
                    else
                    begin
                        for (k = 0; k < stored_count; k++)
                            if (stored_values[k] == it.value)
                                hit = 1'b1;
                        if (hit)
                            r.status = ST_DUP;
                        else
                        begin
                            stored_values[stored_count] = it.value;
                            r.status      = ST_OK;
                            r.position    = stored_count[POS_W-1:0];
                            r.entry_value = it.value;
                            stored_count++;
                        end
                    end
                    expected_results.push_back(r);
                end
                CMD_SEARCH:
                begin
                    r.status = ST_NOTFOUND;
                    for (k = 0; k < stored_count; k++)
                    begin
                        if (!hit && stored_values[k] == it.value)
                        begin
                            hit           = 1'b1;
                            r.status      = ST_OK;
                            r.position    = k[POS_W-1:0];
                            r.entry_value = it.value;
                        end
                    end
                    expected_results.push_back(r);
                end
                CMD_MIN, CMD_MAX:
                begin
                    if (stored_count == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        for (k = 1; k < stored_count; k++)
                        begin
                            if (it.cmd == CMD_MIN ? stored_values[k] < stored_values[best]
                                                  : stored_values[best] < stored_values[k])
                                best = k;
                        end
                        r.status      = ST_OK;
                        r.position    = best[POS_W-1:0];
                        r.entry_value = stored_values[best];
                    end
                    expected_results.push_back(r);
                end
                CMD_DRAIN:
                begin
                    if (stored_count == 0)
                    begin
                        r.status = ST_EMPTY;
                        expected_results.push_back(r);
                    end
                    else
                    begin
                        for (k = 0; k < stored_count; k++)
                        begin
                            idx           = drain_oldest_first ? k : stored_count - 1 - k;
                            r.status      = ST_OK;
                            r.position    = idx[POS_W-1:0];
                            r.entry_value = stored_values[idx];
                            r.last        = (k == stored_count - 1);
                            expected_results.push_back(r);
                        end
                        stored_count = 0;
                    end
                end
                default:
                begin
                    // unknown command: no result, table unchanged
                end
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        rsp_item_t exp_r;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                drain_oldest_first = cfg_drain_order;
            if (cmd_valid && !cmd_stall)
                predict_table_results(cmd_item);
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    error_total++;
                    if (error_total <= 10)
                        $display("unexpected result item: status %0d pos %0d value %0d last %0d",
                                 rsp_item.status, rsp_item.position, rsp_item.entry_value,
                                 rsp_item.last);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (rsp_item.status !== exp_r.status
                        || rsp_item.position !== exp_r.position
                        || rsp_item.entry_value !== exp_r.entry_value
                        || rsp_item.last !== exp_r.last)
                    begin
                        error_total++;
                        if (error_total <= 10)
                            $display({"result mismatch: expected status %0d pos %0d value %0d",
                                      " last %0d, got status %0d pos %0d value %0d last %0d"},
                                     exp_r.status, exp_r.position, exp_r.entry_value,
                                     exp_r.last, rsp_item.status, rsp_item.position,
                                     rsp_item.entry_value, rsp_item.last);
                    end
                end
            end
            mismatch_count <= error_total;
            pending_count  <= expected_results.size();
        end
    end

endmodule

>>> sim/tb_unique_value_table.sv
`timescale 1ns / 100ps
// Testbench top for the unique value table: stimulus, handshake pacing and verdict.
// Depends on uvt_pkg, unique_value_table and uvt_result_checker.
module tb_unique_value_table;
    import uvt_pkg::*;

    localparam int DEPTH        = 16;
    localparam int SETTLE       = 40;    // cycles to let a result-free command finish
    localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
    localparam int IDLE_LIMIT   = 4000;  // watchdog: cycles with no handshake at all
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 82;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    cmd_item_t  cmd_item = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    rsp_item_t  rsp_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_drain_order = 1'b0;

    int         mismatch_count;
    int         pending_count;

    // Set by the stimulus once; the receiver process then holds off on its own.
    logic       hold_req = 1'b0;
    bit         hold_done = 1'b0;

    int         drain_weight;
    bit         steady_sender;
    int         burst_left;

    unique_value_table #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .cmd_item       (cmd_item),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp_item       (rsp_item),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_drain_order(cfg_drain_order)
    );

    uvt_result_checker #(
        .TABLE_DEPTH(DEPTH)
    ) result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .cmd_item       (cmd_item),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp_item       (rsp_item),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_drain_order(cfg_drain_order),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Offer one item and hold it until the edge that accepts it.
    // Called at a rising edge; returns at the accepting edge with valid still high.
    task automatic send_cmd(input logic [2:0] cmd, input logic signed [VALUE_W-1:0] value);
        cmd_item_t it;
        begin
            it.cmd   = cmd;
            it.value = value;
            cmd_valid <= 1'b1;
            cmd_item  <= it;
            @(posedge clk);
            while (cmd_stall)
                @(posedge clk);
        end
    endtask

    // Drop valid, wait for every expected result, then let a trailing
    // result-free command run out before anything else happens.
    task automatic wait_drained();
        begin
            cmd_valid <= 1'b0;
            do
                @(posedge clk);
            while (pending_count != 0);
            repeat (SETTLE) @(posedge clk);
        end
    endtask

    // Write drain order; only called while the block is idle.
    task automatic write_drain_order(input logic oldest_first);
        begin
            cfg_valid       <= 1'b1;
            cfg_drain_order <= oldest_first;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Values from a small pool make duplicates and search hits common;
    // now and then take a wide even positive value instead.
    function automatic logic signed [VALUE_W-1:0] pool_value();
        logic [31:0] raw;
        begin
            raw = $urandom;
            if ($urandom_range(0, 4) != 0)
                pool_value = 2 * $urandom_range(1, 24);
            else
                pool_value = {1'b0, raw[30:1], 1'b0};
        end
    endfunction

    // Send one random item, pacing the sender in bursts with gaps.
    task automatic send_random_item();
        int          roll;
        int          gap;
        logic [2:0]  cmd;
        logic [31:0] value;
        begin
            if (burst_left == 0)
            begin
                if (!steady_sender)
                begin
                    cmd_valid <= 1'b0;
                    gap = $urandom_range(1, 10);
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
            roll  = $urandom_range(0, 99);
            value = $urandom;
            if (roll < 4)
                cmd = 3'($urandom_range(0, 7));          // noise, unknown codes included
            else if (roll < 4 + drain_weight)
                cmd = CMD_DRAIN;
            else if (roll < 14 + drain_weight)
                cmd = CMD_MIN;
            else if (roll < 24 + drain_weight)
                cmd = CMD_MAX;
            else if (roll < 44 + drain_weight)
            begin
                cmd = CMD_SEARCH;
                if ($urandom_range(0, 1) != 0)
                    value = pool_value();
            end
            else
            begin
                cmd = CMD_INSERT;
                if ($urandom_range(0, 6) != 0)
                    value = pool_value();
            end
            send_cmd(cmd, value);
        end
    endtask

    // Receiver: stall on a changing pattern, plus one long hold-off on request.
    initial
    begin
        int mode;
        int span;
        int tick;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 150);
            repeat (span)
            begin
                @(posedge clk);
                tick++;
                if (hold_req && !hold_done)
                begin
                    rsp_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= ($urandom_range(0, 3) == 0);
                    2: rsp_stall <= ($urandom_range(0, 3) != 0);
                    default: rsp_stall <= (tick % 5 < 2);
                endcase
            end
        end
    end

    // Watchdog: end the run when no handshake happens for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        int p;
        burst_left    = 0;
        drain_weight  = 8;
        steady_sender = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, stack order.
        write_drain_order(1'b0);
        send_cmd(CMD_DRAIN, 0);                   // empty table cases
        send_cmd(CMD_MIN, 0);
        send_cmd(CMD_MAX, 0);
        send_cmd(CMD_SEARCH, 2);
        send_cmd(CMD_INSERT, 0);                  // zero, odd and negative rejects
        send_cmd(CMD_INSERT, 3);
        send_cmd(CMD_INSERT, 32'sh8000_0000);
        send_cmd(CMD_INSERT, 2);
        send_cmd(CMD_INSERT, 32'sh7FFF_FFFE);
        send_cmd(CMD_INSERT, 2);                  // duplicate
        send_cmd(CMD_SEARCH, 32'sh7FFF_FFFE);
        send_cmd(CMD_SEARCH, 32'shFFFF_FFFF);     // miss
        send_cmd(3'd5, 4);                        // unknown codes are ignored
        send_cmd(3'd7, 32'shFFFF_FFFF);
        for (k = 2; k < DEPTH; k++)
            send_cmd(CMD_INSERT, 2 * k);
        send_cmd(CMD_INSERT, 7);                  // full wins over a bad value
        send_cmd(CMD_MIN, 0);
        send_cmd(CMD_MAX, 0);
        send_cmd(CMD_DRAIN, 0);
        wait_drained();

        // Random phases; vary drain order, drain rate and sender pacing.
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: write_drain_order(1'b1);
                1: write_drain_order(1'b0);
                2: write_drain_order(1'b1);
                default: write_drain_order(1'($urandom_range(0, 1)));
            endcase
            drain_weight  = (p % 3 == 0) ? 2 : ((p % 3 == 1) ? 8 : 15);
            steady_sender = (p == 2);
            burst_left    = 0;
            if (p == 1)
                hold_req <= 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++)
                send_random_item();
            wait_drained();
        end

        if (mismatch_count == 0 && pending_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
